/* hdl/tsgr_pkg.sv */
// ----------------------------------------------------------------------------
// tsgr_pkg: shared definitions for the two-stage grid router
// Grid geometry, FIFO sizing, request codes, item structs and back-end states.
// ----------------------------------------------------------------------------
package tsgr_pkg;

    // Grid geometry. ROWS, GROUP_SIZE and FIFO_DEPTH are powers of two, so key
    // routing and FIFO pointer wrap reduce to bit slices.
    localparam int ROWS       = 4;
    localparam int GROUP_SIZE = 8;
    localparam int FIFO_DEPTH = 16;
    localparam int NCORES     = ROWS * GROUP_SIZE;
    localparam int NSTAGES    = 3;

    // Field widths
    localparam int CORE_W = 5;
    localparam int KEY_W  = 20;
    localparam int PAY_W  = 20;
    localparam int PKT_W  = KEY_W + PAY_W;

    // Derived widths
    localparam int GRP_W   = $clog2(GROUP_SIZE);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int QIDX_W  = GRP_W + ROW_W;
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W  = QIDX_W + PTR_W;
    localparam int MEM_DEPTH = NCORES * FIFO_DEPTH;
    localparam int TOT_W   = $clog2(NSTAGES * NCORES * FIFO_DEPTH + 1);
    localparam int DCNT_W  = $clog2(NCORES + 1);

    // Command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // Request codes
    localparam logic REQ_INJECT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // FIFO stage codes
    typedef logic [1:0] stage_t;
    localparam stage_t STG_INPUT = 2'd0;
    localparam stage_t STG_ROW   = 2'd1;
    localparam stage_t STG_COL   = 2'd2;

    // Classified command handed from front to back
    typedef struct packed {
        logic              is_tick;
        logic [QIDX_W-1:0] core;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
    } cmd_t;

    // Result item held in the output register
    typedef struct packed {
        logic              delivered;
        logic [CORE_W-1:0] out_core;
        logic [KEY_W-1:0]  out_key;
        logic [PAY_W-1:0]  out_payload;
        logic              fabric_empty;
        logic              overflow_seen;
        logic              last;
    } result_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_INJ,
        B_SNAP,
        B_RD,
        B_WR,
        B_EMIT,
        B_NONE
    } back_state_t;

endpackage

/* hdl/tsgr_ifs.sv */
// ----------------------------------------------------------------------------
// tsgr_ifs: request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tsgr_req_if;
    import tsgr_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CORE_W-1:0] core;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;

    modport source (output valid, req_type, core, key, payload, input ready);
    modport sink   (input valid, req_type, core, key, payload, output ready);
endinterface

interface tsgr_res_if;
    import tsgr_pkg::*;

    logic              valid;
    logic              ready;
    logic              delivered;
    logic [CORE_W-1:0] out_core;
    logic [KEY_W-1:0]  out_key;
    logic [PAY_W-1:0]  out_payload;
    logic              fabric_empty;
    logic              overflow_seen;
    logic              last;

    modport source (output valid, delivered, out_core, out_key, out_payload,
                    fabric_empty, overflow_seen, last, input ready);
    modport sink   (input valid, delivered, out_core, out_key, out_payload,
                    fabric_empty, overflow_seen, last, output ready);
endinterface

/* hdl/tsgr_ram.sv */
// ----------------------------------------------------------------------------
// tsgr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsgr_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/tsgr_front.sv */
// ----------------------------------------------------------------------------
// tsgr_front: request intake and classification
// Accepts items, drops injects at nonexistent cores, queues the rest.
// ----------------------------------------------------------------------------
module tsgr_front (
    tsgr_req_if.sink        req,
    output logic            q_push,
    output tsgr_pkg::cmd_t  q_cmd,
    input  logic            q_full
);
    import tsgr_pkg::*;

    logic accept;
    logic core_ok;

    // take an item whenever the queue has room
    assign req.ready = !q_full;
    assign accept    = req.valid && !q_full;

    // injects naming a core outside the grid are swallowed here
    assign core_ok = ({1'b0, req.core} < (CORE_W + 1)'(NCORES));
    assign q_push  = accept && ((req.req_type == REQ_TICK) || core_ok);

    always_comb
    begin
        q_cmd.is_tick = (req.req_type == REQ_TICK);
        q_cmd.core    = req.core[QIDX_W-1:0];
        q_cmd.key     = req.key;
        q_cmd.payload = req.payload;
    end
endmodule

/* hdl/tsgr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// tsgr_cmd_fifo: command queue between front and back
// Small flop-based FIFO of classified commands.
// ----------------------------------------------------------------------------
module tsgr_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsgr_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output tsgr_pkg::cmd_t  head,
    output logic            empty
);
    import tsgr_pkg::*;

    cmd_t                mem_reg [0:CQ_DEPTH-1];
    logic [CQ_PTR_W-1:0] wp_reg, wp_next;
    logic [CQ_PTR_W-1:0] rp_reg, rp_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rp_reg];

    // pointer and occupancy update
    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= push_cmd;
        end
    end
endmodule

/* hdl/tsgr_back.sv */
// ----------------------------------------------------------------------------
// tsgr_back: fabric engine
// Runs injects and ticks against the three packet stores; drives the result
// output register.
// ----------------------------------------------------------------------------
module tsgr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  tsgr_pkg::cmd_t  q_head,
    output logic            q_pop,
    tsgr_res_if.source      res
);
    import tsgr_pkg::*;

    back_state_t state_reg, state_next;

    cmd_t                   cmd_reg, cmd_next;
    stage_t                 st_reg, st_next;
    logic [QIDX_W-1:0]      q_reg, q_next;
    logic [NSTAGES-1:0][NCORES-1:0] elig_reg, elig_next;
    logic [CNT_W-1:0]       cnt_reg [0:NSTAGES-1][0:NCORES-1];
    logic [CNT_W-1:0]       cnt_next [0:NSTAGES-1][0:NCORES-1];
    logic [PTR_W-1:0]       rp_reg [0:NSTAGES-1][0:NCORES-1];
    logic [PTR_W-1:0]       rp_next [0:NSTAGES-1][0:NCORES-1];
    logic                   ovf_reg, ovf_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [DCNT_W-1:0]      dcnt_reg, dcnt_next;
    result_t                out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    // RAM ports
    logic [NSTAGES-1:0]             ram_we;
    logic [NSTAGES-1:0]             ram_re;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [ADDR_W-1:0]              ram_raddr;
    logic [PKT_W-1:0]               ram_wdata;
    logic [NSTAGES-1:0][PKT_W-1:0]  ram_rdata;

    // control strobes
    logic        out_free;
    logic        elig_cur;
    logic        q_last;
    logic        do_inj, do_snap, do_move, do_emit, do_none, do_adv;
    logic        inj_full, mv_full;
    stage_t      dst_st;
    logic [PKT_W-1:0]  pkt;
    logic [KEY_W-1:0]  pkt_key;
    logic [QIDX_W-1:0] dest;
    logic [CNT_W-1:0]  dst_cnt;
    logic [CNT_W-1:0]  inj_cnt;
    back_state_t       after_adv;

    // packet stores: input, row and column FIFOs
    for (genvar s = 0; s < NSTAGES; s++)
    begin : g_store
        tsgr_ram #(
            .WIDTH (PKT_W),
            .DEPTH (MEM_DEPTH)
        ) u_store (
            .clk   (clk),
            .we    (ram_we[s]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (ram_re[s]),
            .raddr (ram_raddr),
            .rdata (ram_rdata[s])
        );
    end

    // shared decode
    assign out_free = !out_valid_reg || res.ready;
    assign elig_cur = elig_reg[st_reg][q_reg];
    assign q_last   = (q_reg == QIDX_W'(NCORES - 1));
    assign dst_st   = (st_reg == STG_INPUT) ? STG_ROW : STG_COL;
    assign pkt      = ram_rdata[st_reg];
    assign pkt_key  = pkt[PKT_W-1:PAY_W];
    // input -> row FIFO in the key's row; row -> column FIFO named by key
    assign dest     = (st_reg == STG_INPUT)
                    ? {pkt_key[QIDX_W-1:GRP_W], q_reg[GRP_W-1:0]}
                    : {q_reg[QIDX_W-1:GRP_W], pkt_key[GRP_W-1:0]};
    assign dst_cnt  = cnt_reg[dst_st][dest];
    assign mv_full  = (dst_cnt == CNT_W'(FIFO_DEPTH));
    assign inj_cnt  = cnt_reg[STG_INPUT][cmd_reg.core];
    assign inj_full = (inj_cnt == CNT_W'(FIFO_DEPTH));

    // where the sweep goes after finishing the current core
    always_comb
    begin
        after_adv = B_RD;
        if (q_last)
        begin
            case (st_reg)
                STG_INPUT: after_adv = B_RD;
                STG_ROW:   after_adv = (dcnt_reg == '0) ? B_NONE : B_RD;
                default:   after_adv = B_IDLE;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_head.is_tick ? B_SNAP : B_INJ;
                end
            end
            B_INJ:  state_next = B_IDLE;
            B_SNAP: state_next = B_RD;
            B_RD:
            begin
                if (elig_cur)
                begin
                    state_next = (st_reg == STG_COL) ? B_EMIT : B_WR;
                end
                else
                begin
                    state_next = after_adv;
                end
            end
            B_WR:   state_next = after_adv;
            B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = after_adv;
                end
            end
            B_NONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // state outputs: strobes and RAM controls
    always_comb
    begin
        q_pop   = 1'b0;
        do_inj  = 1'b0;
        do_snap = 1'b0;
        do_move = 1'b0;
        do_emit = 1'b0;
        do_none = 1'b0;
        do_adv  = 1'b0;
        ram_re  = '0;
        ram_we  = '0;
        ram_raddr = {q_reg, rp_reg[st_reg][q_reg]};
        ram_waddr = {dest, rp_reg[dst_st][dest] + dst_cnt[PTR_W-1:0]};
        ram_wdata = pkt;
        case (state_reg)
            B_IDLE: q_pop = !q_empty;
            B_INJ:
            begin
                do_inj    = 1'b1;
                ram_we[STG_INPUT] = !inj_full;
                ram_waddr = {cmd_reg.core,
                             rp_reg[STG_INPUT][cmd_reg.core] + inj_cnt[PTR_W-1:0]};
                ram_wdata = {cmd_reg.key, cmd_reg.payload};
            end
            B_SNAP: do_snap = 1'b1;
            B_RD:
            begin
                ram_re[st_reg] = elig_cur;
                do_adv = !elig_cur;
            end
            B_WR:
            begin
                do_move = 1'b1;
                do_adv  = 1'b1;
                ram_we[dst_st] = !mv_full;
            end
            B_EMIT:
            begin
                do_emit = out_free;
                do_adv  = out_free;
            end
            B_NONE: do_none = out_free;
            default: q_pop = 1'b0;
        endcase
    end

    // datapath register updates
    always_comb
    begin
        cmd_next   = cmd_reg;
        st_next    = st_reg;
        q_next     = q_reg;
        elig_next  = elig_reg;
        cnt_next   = cnt_reg;
        rp_next    = rp_reg;
        ovf_next   = ovf_reg;
        total_next = total_reg;
        dcnt_next  = dcnt_reg;
        out_next   = out_reg;
        out_valid_next = (out_valid_reg && !res.ready);

        if (q_pop)
        begin
            cmd_next = q_head;
        end

        // inject into the core's input FIFO
        if (do_inj)
        begin
            if (inj_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_next[STG_INPUT][cmd_reg.core] = inj_cnt + 1'b1;
                total_next = total_reg + 1'b1;
            end
        end

        // snapshot which FIFOs may move this tick
        if (do_snap)
        begin
            for (int s = 0; s < NSTAGES; s++)
            begin
                for (int i = 0; i < NCORES; i++)
                begin
                    elig_next[s][i] = (cnt_reg[s][i] != '0);
                end
            end
            st_next   = STG_INPUT;
            q_next    = '0;
            dcnt_next = '0;
        end

        // count this tick's deliveries during the first sweep
        if ((state_reg == B_RD) && (st_reg == STG_INPUT))
        begin
            dcnt_next = dcnt_reg + DCNT_W'(elig_reg[STG_COL][q_reg]);
        end

        // one hop: pop source, push destination or drop
        if (do_move)
        begin
            cnt_next[st_reg][q_reg] = cnt_reg[st_reg][q_reg] - 1'b1;
            rp_next[st_reg][q_reg]  = rp_reg[st_reg][q_reg] + 1'b1;
            if (mv_full)
            begin
                ovf_next   = 1'b1;
                total_next = total_reg - 1'b1;
            end
            else
            begin
                cnt_next[dst_st][dest] = dst_cnt + 1'b1;
            end
        end

        // delivery from a column FIFO
        if (do_emit)
        begin
            cnt_next[STG_COL][q_reg] = cnt_reg[STG_COL][q_reg] - 1'b1;
            rp_next[STG_COL][q_reg]  = rp_reg[STG_COL][q_reg] + 1'b1;
            total_next = total_reg - 1'b1;
            dcnt_next  = dcnt_reg - 1'b1;
            out_valid_next        = 1'b1;
            out_next.delivered    = 1'b1;
            out_next.out_core     = CORE_W'(q_reg);
            out_next.out_key      = pkt_key;
            out_next.out_payload  = pkt[PAY_W-1:0];
            // packets left after the tick = total minus pending deliveries
            out_next.fabric_empty = (total_reg == TOT_W'(dcnt_reg));
            out_next.overflow_seen = ovf_reg;
            out_next.last         = (dcnt_reg == DCNT_W'(1));
        end

        // tick with nothing delivered
        if (do_none)
        begin
            out_valid_next        = 1'b1;
            out_next.delivered    = 1'b0;
            out_next.out_core     = '0;
            out_next.out_key      = '0;
            out_next.out_payload  = '0;
            out_next.fabric_empty = (total_reg == '0);
            out_next.overflow_seen = ovf_reg;
            out_next.last         = 1'b1;
        end

        // step to the next core / stage; the column sweep wraps to input
        if (do_adv)
        begin
            q_next = q_last ? '0 : q_reg + 1'b1;
            if (q_last)
            begin
                st_next = (st_reg == STG_COL) ? STG_INPUT : st_reg + 2'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            st_reg        <= STG_INPUT;
            q_reg         <= '0;
            elig_reg      <= '0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NSTAGES; s++)
            begin
                for (int i = 0; i < NCORES; i++)
                begin
                    cnt_reg[s][i] <= '0;
                    rp_reg[s][i]  <= '0;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            q_reg         <= q_next;
            elig_reg      <= elig_next;
            ovf_reg       <= ovf_next;
            total_reg     <= total_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            rp_reg        <= rp_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    // result channel
    assign res.valid         = out_valid_reg;
    assign res.delivered     = out_reg.delivered;
    assign res.out_core      = out_reg.out_core;
    assign res.out_key       = out_reg.out_key;
    assign res.out_payload   = out_reg.out_payload;
    assign res.fabric_empty  = out_reg.fabric_empty;
    assign res.overflow_seen = out_reg.overflow_seen;
    assign res.last          = out_reg.last;
endmodule

/* hdl/two_stage_grid_router_unit.sv */
// An accepted inject is queued, popped in B_IDLE and written to its input FIFO
// in B_INJ. A tick runs B_SNAP, a sweep of the input FIFOs and one of the row
// FIFOs (B_RD per core, B_WR per moved packet), then, when any column FIFO
// delivers, a column sweep with B_EMIT per delivery, else the single empty result
// in B_NONE; result stalls hold B_EMIT and B_NONE. Each command ends before another.
// Reset: asynchronous, clears all FIFO counts, pointers and the overflow flag.
// ----------------------------------------------------------------------------
// two_stage_grid_router_unit: two-hop grid packet router
// Front classifies and queues items; back moves packets through the fabric.
// ----------------------------------------------------------------------------
module two_stage_grid_router_unit (
    input  logic       clk,
    input  logic       rst_n,
    tsgr_req_if.sink   req,
    tsgr_res_if.source res
);
    import tsgr_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    tsgr_front u_front (
        .req    (req),
        .q_push (q_push),
        .q_cmd  (q_cmd),
        .q_full (q_full)
    );

    tsgr_cmd_fifo u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    tsgr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .res     (res)
    );

`ifndef ASSERT_OFF
    // a result with no packet always closes its tick
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.delivered |-> res.last)
        else $error("non-delivering result without last");

    // a result with no packet carries zero fields
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.delivered |->
            res.out_core == '0 && res.out_key == '0 && res.out_payload == '0)
        else $error("non-delivering result with nonzero fields");

    // front never pushes into a full command queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("command pushed into full queue");
`endif
endmodule
